/* design/mccm_pkg.sv */
// Package: shared types and constants for the MIDI controller-to-slot map.
package mccm_pkg;

  localparam int SLOT_COUNT_DEF = 64;

  localparam int CHAN_W   = 4;
  localparam int TYPE_W   = 4;
  localparam int BYTE_W   = 8;
  localparam int KEY_W    = CHAN_W + BYTE_W;
  localparam int SLOT_W   = 6;
  localparam int SCALED_W = 46;
  localparam int CHF_W    = 5;
  localparam int PTF_W    = 9;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 3;

  localparam logic [37:0] SCALE_FACTOR = 38'h20_4081_0204;

  localparam logic KIND_MSG  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  localparam logic [TYPE_W-1:0] MSG_NOTE_OFF   = 4'd8;
  localparam logic [TYPE_W-1:0] MSG_NOTE_ON    = 4'd9;
  localparam logic [TYPE_W-1:0] MSG_PITCH_BEND = 4'd14;

  localparam logic [BYTE_W-1:0] CC_ALL_NOTES_OFF = 8'd123;
  localparam logic [BYTE_W-1:0] CC_DATA_ENTRY    = 8'd6;
  localparam logic [BYTE_W-1:0] CC_VOLUME        = 8'd7;
  localparam logic [BYTE_W-1:0] CC_RPN_LSB       = 8'd100;
  localparam logic [BYTE_W-1:0] CC_RPN_MSB       = 8'd101;

  localparam logic REG_CHANNEL = 1'b0;
  localparam logic REG_PORT    = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [CHAN_W-1:0] midi_channel;
    logic [TYPE_W-1:0] msg_type;
    logic [BYTE_W-1:0] data_first;
    logic [BYTE_W-1:0] data_second;
    logic [BYTE_W-1:0] port_number;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0]   slot_index;
    logic [BYTE_W-1:0]   raw_level;
    logic [SCALED_W-1:0] scaled_level;
    logic                last;
  } out_item_t;

  typedef struct packed {
    logic [CHF_W-1:0] channel_filter;
    logic [PTF_W-1:0] port_filter;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic last;
  } emit_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FLUSH
  } state_t;

endpackage

/* design/midi_cc_to_controller_map.sv */
// Top level: MIDI controller-to-slot map.
//
// Input: an item (MIDI message or tick) is taken when start is high and busy
// is low. A message that passes the filters is searched for in the key RAM,
// one slot per cycle; a known key updates its level, a new key takes the next
// free slot if one is left. A filtered message, or one into an empty table, is
// handled in idle without a search.
// A tick with an update pending reads the level RAM one slot per cycle and
// sends one result per used slot on result, each marked by strobe for one
// cycle; last marks the final slot. Each result passes the RAM read register
// and the result register; busy drops as strobe marks the final result.
// Throughput is set by the single read port of each slot RAM: one slot per cycle.
// Results cannot be held off by the receiver.
// Configuration: APB writes to channel_filter (0x0) and port_filter (0x4),
// done while busy is low. Reset clears the slot count, the pending mark and
// both filters; slot RAM contents need no clearing.
module midi_cc_to_controller_map #(
  parameter int SLOT_COUNT = mccm_pkg::SLOT_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  mccm_pkg::in_item_t          item,
  output logic                        strobe,
  output mccm_pkg::out_item_t         result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mccm_pkg::ADDR_W-1:0] paddr,
  input  logic [mccm_pkg::DATA_W-1:0] pwdata,
  output logic [mccm_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  mccm_pkg::cfg_t              cfg;
  mccm_pkg::emit_t             emit;
  logic [IDX_W-1:0]            emit_idx;
  logic                        key_we, lvl_we;
  logic [IDX_W-1:0]            waddr, raddr;
  logic [mccm_pkg::KEY_W-1:0]  key_wdata, key_rdata;
  logic [mccm_pkg::BYTE_W-1:0] lvl_wdata, lvl_rdata;

  mccm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mccm_ctrl #(
    .SLOT_COUNT (SLOT_COUNT),
    .IDX_W      (IDX_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .cfg       (cfg),
    .key_we    (key_we),
    .lvl_we    (lvl_we),
    .waddr     (waddr),
    .key_wdata (key_wdata),
    .lvl_wdata (lvl_wdata),
    .raddr     (raddr),
    .key_rdata (key_rdata),
    .emit      (emit),
    .emit_idx  (emit_idx)
  );

  mccm_ram #(
    .WIDTH (mccm_pkg::KEY_W),
    .DEPTH (SLOT_COUNT),
    .AW    (IDX_W)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (waddr),
    .wdata (key_wdata),
    .raddr (raddr),
    .rdata (key_rdata)
  );

  mccm_ram #(
    .WIDTH (mccm_pkg::BYTE_W),
    .DEPTH (SLOT_COUNT),
    .AW    (IDX_W)
  ) u_lvl_ram (
    .clk   (clk),
    .we    (lvl_we),
    .waddr (waddr),
    .wdata (lvl_wdata),
    .raddr (raddr),
    .rdata (lvl_rdata)
  );

  mccm_emit #(
    .IDX_W (IDX_W)
  ) u_emit (
    .clk       (clk),
    .rst       (rst),
    .emit      (emit),
    .emit_idx  (emit_idx),
    .lvl_rdata (lvl_rdata),
    .strobe    (strobe),
    .result    (result)
  );

endmodule

/* design/mccm_ram.sv */
// Generic simple dual-port RAM with registered read.
module mccm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/mccm_cfg.sv */
// APB configuration registers: channel and port filters.
module mccm_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mccm_pkg::ADDR_W-1:0] paddr,
  input  logic [mccm_pkg::DATA_W-1:0] pwdata,
  output logic [mccm_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output mccm_pkg::cfg_t              cfg
);

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr) begin
      if (paddr[2] == mccm_pkg::REG_CHANNEL) begin
        cfg.channel_filter <= pwdata[mccm_pkg::CHF_W-1:0];
      end else begin
        cfg.port_filter <= pwdata[mccm_pkg::PTF_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == mccm_pkg::REG_CHANNEL) begin
      prdata = mccm_pkg::DATA_W'(cfg.channel_filter);
    end else begin
      prdata = mccm_pkg::DATA_W'(cfg.port_filter);
    end
  end

endmodule

/* design/mccm_ctrl.sv */
// Sequencer: filtering, key search, slot insert and tick flush over the slot RAMs.
module mccm_ctrl #(
  parameter int SLOT_COUNT = mccm_pkg::SLOT_COUNT_DEF,
  parameter int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  mccm_pkg::in_item_t          item,
  input  mccm_pkg::cfg_t              cfg,
  output logic                        key_we,
  output logic                        lvl_we,
  output logic [IDX_W-1:0]            waddr,
  output logic [mccm_pkg::KEY_W-1:0]  key_wdata,
  output logic [mccm_pkg::BYTE_W-1:0] lvl_wdata,
  output logic [IDX_W-1:0]            raddr,
  input  logic [mccm_pkg::KEY_W-1:0]  key_rdata,
  output mccm_pkg::emit_t             emit,
  output logic [IDX_W-1:0]            emit_idx
);

  localparam int CNT_W = $clog2(SLOT_COUNT + 1);

  mccm_pkg::state_t state, state_next;

  logic [CNT_W-1:0]            slots_used, slots_used_next;
  logic                        pending, pending_next;
  logic [CNT_W-1:0]            cnt, cnt_next;
  logic                        rd_valid, rd_valid_next;
  logic [IDX_W-1:0]            rd_idx, rd_idx_next;
  logic [mccm_pkg::KEY_W-1:0]  key, key_next;
  logic [mccm_pkg::BYTE_W-1:0] level, level_next;

  logic                        chan_ok, port_ok, type_ok, cc_ok, msg_ok;
  logic                        rd_last, has_room;
  logic [mccm_pkg::KEY_W-1:0]  item_key;

  assign busy     = (state != mccm_pkg::ST_IDLE);
  assign item_key = {item.midi_channel, item.data_first};
  assign rd_last  = (CNT_W'(rd_idx) + CNT_W'(1)) == slots_used;
  assign has_room = slots_used < CNT_W'(SLOT_COUNT);

  assign chan_ok = (cfg.channel_filter == '0) ||
                   ((mccm_pkg::CHF_W'(item.midi_channel) + mccm_pkg::CHF_W'(1)) ==
                    cfg.channel_filter);
  assign port_ok = (cfg.port_filter == '0) ||
                   ((mccm_pkg::PTF_W'(item.port_number) + mccm_pkg::PTF_W'(1)) ==
                    cfg.port_filter);

  always_comb begin
    case (item.msg_type)
      mccm_pkg::MSG_NOTE_OFF,
      mccm_pkg::MSG_NOTE_ON,
      mccm_pkg::MSG_PITCH_BEND: type_ok = 1'b0;
      default:                  type_ok = 1'b1;
    endcase
    case (item.data_first)
      mccm_pkg::CC_ALL_NOTES_OFF,
      mccm_pkg::CC_DATA_ENTRY,
      mccm_pkg::CC_VOLUME,
      mccm_pkg::CC_RPN_LSB,
      mccm_pkg::CC_RPN_MSB:     cc_ok = 1'b0;
      default:                  cc_ok = 1'b1;
    endcase
  end

  assign msg_ok = chan_ok && port_ok && type_ok && cc_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= mccm_pkg::ST_IDLE;
      slots_used <= '0;
      pending    <= 1'b0;
      rd_valid   <= 1'b0;
      cnt        <= '0;
    end else begin
      state      <= state_next;
      slots_used <= slots_used_next;
      pending    <= pending_next;
      rd_valid   <= rd_valid_next;
      cnt        <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= rd_idx_next;
    key    <= key_next;
    level  <= level_next;
  end

  always_comb begin
    state_next      = state;
    slots_used_next = slots_used;
    pending_next    = pending;
    cnt_next        = cnt;
    rd_valid_next   = 1'b0;
    rd_idx_next     = rd_idx;
    key_next        = key;
    level_next      = level;
    key_we          = 1'b0;
    lvl_we          = 1'b0;
    waddr           = slots_used[IDX_W-1:0];
    key_wdata       = key;
    lvl_wdata       = level;
    raddr           = cnt[IDX_W-1:0];
    emit            = '0;
    emit_idx        = rd_idx;

    case (state)
      mccm_pkg::ST_IDLE: begin
        cnt_next = '0;
        if (start) begin
          if (item.kind == mccm_pkg::KIND_MSG) begin
            key_next   = item_key;
            level_next = item.data_second;
            if (msg_ok) begin
              if (slots_used == '0) begin
                key_we          = 1'b1;
                lvl_we          = 1'b1;
                key_wdata       = item_key;
                lvl_wdata       = item.data_second;
                slots_used_next = slots_used + CNT_W'(1);
                pending_next    = 1'b1;
              end else begin
                state_next = mccm_pkg::ST_SEARCH;
              end
            end
          end else if (pending && slots_used != '0) begin
            state_next = mccm_pkg::ST_FLUSH;
          end
        end
      end

      mccm_pkg::ST_SEARCH: begin
        if (cnt < slots_used) begin
          rd_valid_next = 1'b1;
          rd_idx_next   = cnt[IDX_W-1:0];
          cnt_next      = cnt + CNT_W'(1);
        end
        if (rd_valid) begin
          if (key_rdata == key) begin
            lvl_we        = 1'b1;
            waddr         = rd_idx;
            pending_next  = 1'b1;
            rd_valid_next = 1'b0;
            state_next    = mccm_pkg::ST_IDLE;
          end else if (rd_last) begin
            if (has_room) begin
              key_we          = 1'b1;
              lvl_we          = 1'b1;
              slots_used_next = slots_used + CNT_W'(1);
              pending_next    = 1'b1;
            end
            rd_valid_next = 1'b0;
            state_next    = mccm_pkg::ST_IDLE;
          end
        end
      end

      mccm_pkg::ST_FLUSH: begin
        if (cnt < slots_used) begin
          rd_valid_next = 1'b1;
          rd_idx_next   = cnt[IDX_W-1:0];
          cnt_next      = cnt + CNT_W'(1);
        end
        if (rd_valid) begin
          emit.valid = 1'b1;
          emit.last  = rd_last;
          if (rd_last) begin
            pending_next  = 1'b0;
            rd_valid_next = 1'b0;
            state_next    = mccm_pkg::ST_IDLE;
          end
        end
      end

      default: begin
        state_next = mccm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* design/mccm_emit.sv */
// Result stage: scales the slot level and registers the result transfer.
module mccm_emit #(
  parameter int IDX_W = 6
) (
  input  logic                        clk,
  input  logic                        rst,
  input  mccm_pkg::emit_t             emit,
  input  logic [IDX_W-1:0]            emit_idx,
  input  logic [mccm_pkg::BYTE_W-1:0] lvl_rdata,
  output logic                        strobe,
  output mccm_pkg::out_item_t         result
);

  logic [mccm_pkg::SCALED_W-1:0] scaled;

  assign scaled = mccm_pkg::SCALED_W'(lvl_rdata) *
                  mccm_pkg::SCALED_W'(mccm_pkg::SCALE_FACTOR);

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= emit.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      result.slot_index   <= mccm_pkg::SLOT_W'(emit_idx);
      result.raw_level    <= lvl_rdata;
      result.scaled_level <= scaled;
      result.last         <= emit.last;
    end
  end

endmodule
